[design/fes_pkg.sv]
// Shared types, codes and helpers for the flash/EEPROM byte store.
// No dependencies.
package fes_pkg;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_PROGRAM = 2'd1;
   localparam logic [1:0] OP_ERASE   = 2'd2;

   localparam logic [1:0] CSR_FLASH_MODE   = 2'd0;
   localparam logic [1:0] CSR_STORAGE      = 2'd1;
   localparam logic [1:0] CSR_PROGRAM_UNIT = 2'd2;
   localparam logic [1:0] CSR_ERASE_UNIT   = 2'd3;

   localparam logic [7:0]  ERASED_BYTE  = 8'hFF;
   localparam logic [16:0] MAX_READ_LEN = 17'h0FFFF;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BITSET  = 2'd2,
      ST_SKIPPED = 2'd3
   } fes_status_type;

   typedef struct packed {
      logic        flash_mode;
      logic [16:0] storage_bytes;
      logic [3:0]  program_unit_log2;
      logic [4:0]  erase_unit_log2;
   } fes_cfg_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] req_type;
      logic       off_zero;
      logic [7:0] write_byte;
   } fes_item_type;

   function automatic logic is_aligned(input logic [16:0] v, input logic [4:0] lg);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 17; i++) begin
         ok = ok & ~(v[i] & (5'(i) < lg));
      end
      return ok;
   endfunction

endpackage

[design/fes_if.sv]
// Request and response channel interfaces for the byte store.
// Depends on nothing; widths are the fixed field widths.
interface fes_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] start_addr;
   logic [16:0] txn_length;
   logic [15:0] byte_offset;
   logic [7:0]  write_byte;
   modport source (output valid, req_type, start_addr, txn_length, byte_offset, write_byte,
                   input ready);
   modport sink (input valid, req_type, start_addr, txn_length, byte_offset, write_byte,
                 output ready);
endinterface

interface fes_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic [1:0] status;
   modport source (output valid, read_byte, status, input ready);
   modport sink (input valid, read_byte, status, output ready);
endinterface

[design/fes_check.sv]
// Range, alignment and type check of one beat, plus its byte address.
// Depends on fes_pkg.
module fes_check import fes_pkg::*; #(
   parameter int MEM_BYTES = 65536,
   parameter int AW = 16
) (
   input  fes_cfg_type  cfg,
   input  logic [1:0]   req_type,
   input  logic [15:0]  start_addr,
   input  logic [16:0]  txn_length,
   input  logic [15:0]  byte_offset,
   input  logic [7:0]   write_byte,
   output fes_item_type item,
   output logic [AW-1:0] addr
);
   localparam int LW = (AW + 1 > 18) ? AW + 1 : 18;
   localparam int SW = (AW > 17) ? AW : 17;

   logic [LW-1:0] limit;
   logic [LW-1:0] end_sum;
   logic [SW-1:0] addr_sum;
   logic          range_ok;
   logic          type_ok;

   always_comb begin
      limit = (LW'(cfg.storage_bytes) < LW'(MEM_BYTES)) ? LW'(cfg.storage_bytes)
                                                        : LW'(MEM_BYTES);
      end_sum  = LW'(start_addr) + LW'(txn_length);
      range_ok = (txn_length != 17'd0) && (end_sum <= limit)
                 && ({1'b0, byte_offset} < txn_length);
      case (req_type)
         OP_READ: begin
            type_ok = (txn_length <= MAX_READ_LEN);
         end
         OP_PROGRAM: begin
            type_ok = !cfg.flash_mode
                      || is_aligned({1'b0, start_addr}, {1'b0, cfg.program_unit_log2});
         end
         OP_ERASE: begin
            type_ok = cfg.flash_mode
                      && is_aligned({1'b0, start_addr}, cfg.erase_unit_log2)
                      && is_aligned(txn_length, cfg.erase_unit_log2);
         end
         default: begin
            type_ok = 1'b0;
         end
      endcase
      addr_sum        = SW'(start_addr) + SW'(byte_offset);
      addr            = addr_sum[AW-1:0];
      item.ok         = range_ok && type_ok;
      item.req_type   = req_type;
      item.off_zero   = (byte_offset == 16'd0);
      item.write_byte = write_byte;
   end
endmodule

[design/fes_mem.sv]
// Byte array with registered read, write-to-read forwarding and an erase sweep
// after reset. Depends on fes_pkg.
module fes_mem import fes_pkg::*; #(
   parameter int MEM_BYTES = 65536,
   parameter int AW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data,
   output logic          clr_busy
);
   logic [7:0]    cell_bytes [MEM_BYTES];
   logic [7:0]    rd_data_ff;
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   always_comb begin
      mem_we      = clr_busy_ff || wr_en;
      mem_wa      = clr_busy_ff ? clr_addr_ff : wr_addr;
      mem_wd      = clr_busy_ff ? ERASED_BYTE : wr_data;
      clr_addr_in = clr_addr_ff + AW'(1);
      clr_busy_in = clr_busy_ff && (clr_addr_ff != AW'(MEM_BYTES - 1));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_bytes[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : cell_bytes[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;
endmodule

[design/flash_eeprom_byte_store.sv]
// Top level of the flash/EEPROM byte store: CSRs, read-modify-write stage, output register.
// Depends on fes_pkg, fes_if, fes_check and fes_mem.
//
//   channel   dir  handshake           payload
//   req_bus   in   valid/ready         req_type start_addr txn_length byte_offset write_byte
//   rsp_bus   out  valid/ready         read_byte status
//   csr_*     in   csr_wr_en           csr_index csr_wdata
//
// One beat per cycle when rsp_bus does not stall: read at accept, modify and write back
// in the modify stage, with forwarding from that write to the next beat's read of the same byte.
// rsp_bus.valid rises once the beat has passed the modify stage and the output register.
// After reset an erase sweep fills the array with 0xFF, with ready held low.
// A stalled rsp_bus holds the output register and the modify stage.
module flash_eeprom_byte_store import fes_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   fes_req_if.sink     req_bus,
   fes_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   localparam int AW = $clog2(MEM_BYTES);

   fes_cfg_type    cfg_ff, cfg_in;
   fes_item_type   chk_item;
   logic [AW-1:0]  chk_addr;
   fes_item_type   s2_item_ff, s2_item_in;
   logic [AW-1:0]  s2_addr_ff, s2_addr_in;
   logic           s2_valid_ff, s2_valid_in;
   logic           txn_failed_ff, txn_failed_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_read_byte_ff, rsp_read_byte_in;
   fes_status_type rsp_status_ff, rsp_status_in;
   logic           clr_busy;
   logic           out_free;
   logic           s2_move;
   logic           req_fire;
   logic [7:0]     cur_byte;
   logic           wr_req;
   logic [7:0]     wr_data;
   logic [7:0]     rd_out;
   fes_status_type st_out;
   logic           failed_eff;

   fes_check #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_check (
      .cfg         (cfg_ff),
      .req_type    (req_bus.req_type),
      .start_addr  (req_bus.start_addr),
      .txn_length  (req_bus.txn_length),
      .byte_offset (req_bus.byte_offset),
      .write_byte  (req_bus.write_byte),
      .item        (chk_item),
      .addr        (chk_addr)
   );

   fes_mem #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (chk_addr),
      .wr_en    (wr_req && s2_move),
      .wr_addr  (s2_addr_ff),
      .wr_data  (wr_data),
      .rd_data  (cur_byte),
      .clr_busy (clr_busy)
   );

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s2_move       = s2_valid_ff && out_free;
   assign req_bus.ready = !clr_busy && (!s2_valid_ff || out_free);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // modify stage
   always_comb begin
      failed_eff = s2_item_ff.off_zero ? 1'b0 : txn_failed_ff;
      wr_req     = 1'b0;
      wr_data    = s2_item_ff.write_byte;
      rd_out     = 8'd0;
      st_out     = ST_OK;
      if (!s2_item_ff.ok) begin
         st_out = ST_INVALID;
      end else begin
         case (s2_item_ff.req_type)
            OP_READ: begin
               rd_out = cur_byte;
            end
            OP_ERASE: begin
               wr_req  = 1'b1;
               wr_data = ERASED_BYTE;
            end
            OP_PROGRAM: begin
               if (failed_eff) begin
                  st_out = ST_SKIPPED;
               end else if (cfg_ff.flash_mode) begin
                  if ((cur_byte & s2_item_ff.write_byte) != s2_item_ff.write_byte) begin
                     st_out = ST_BITSET;
                  end else begin
                     wr_req  = 1'b1;
                     wr_data = cur_byte & s2_item_ff.write_byte;
                  end
               end else begin
                  wr_req = 1'b1;
               end
            end
            default: begin
               st_out = ST_INVALID;
            end
         endcase
      end
   end

   always_comb begin
      s2_valid_in      = req_fire ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      s2_item_in       = req_fire ? chk_item : s2_item_ff;
      s2_addr_in       = req_fire ? chk_addr : s2_addr_ff;
      txn_failed_in    = s2_move ? (failed_eff || (st_out == ST_BITSET)) : txn_failed_ff;
      rsp_valid_in     = out_free ? s2_valid_ff : rsp_valid_ff;
      rsp_read_byte_in = s2_move ? rd_out : rsp_read_byte_ff;
      rsp_status_in    = s2_move ? st_out : rsp_status_ff;
      cfg_in           = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FLASH_MODE:   cfg_in.flash_mode        = csr_wdata[0];
            CSR_STORAGE:      cfg_in.storage_bytes     = csr_wdata;
            CSR_PROGRAM_UNIT: cfg_in.program_unit_log2 = csr_wdata[3:0];
            CSR_ERASE_UNIT:   cfg_in.erase_unit_log2   = csr_wdata[4:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_mode        <= 1'b1;
         cfg_ff.storage_bytes     <= 17'h10000;
         cfg_ff.program_unit_log2 <= 4'd3;
         cfg_ff.erase_unit_log2   <= 5'd11;
         s2_valid_ff              <= 1'b0;
         txn_failed_ff            <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         s2_valid_ff   <= s2_valid_in;
         txn_failed_ff <= txn_failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_item_ff       <= s2_item_in;
      s2_addr_ff       <= s2_addr_in;
      rsp_read_byte_ff <= rsp_read_byte_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_byte = rsp_read_byte_ff;
   assign rsp_bus.status    = rsp_status_ff;
endmodule

[design/fes_sva.sv]
// Port-level checks for the flash/EEPROM byte store, bound to the top level.
// Depends on fes_pkg.
module fes_sva import fes_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_byte,
   input logic [1:0] rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_read_byte == 8'd0)
      else $error("read_byte nonzero on failed beat");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("accepted beat produced no response");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");
endmodule

bind flash_eeprom_byte_store fes_sva u_fes_sva (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_read_byte (rsp_bus.read_byte),
   .rsp_status    (rsp_bus.status)
);

[test/tb_top.sv]
// Self-checking bench for flash_eeprom_byte_store: directed table, then random transactions
// checked beat by beat against an in-bench byte-store predictor across several CSR settings.
// Depends on fes_pkg, fes_if and the design files.
module tb_top;
   import fes_pkg::*;

   localparam int MEM_BYTES = 65536;
   localparam int STALL_LIMIT = 200000;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] start;
      logic [16:0] len;
      logic [15:0] off;
      logic [7:0]  wb;
   } byte_req_t;

   typedef struct packed {
      logic [7:0]     read_byte;
      fes_status_type status;
   } byte_result_t;

   typedef struct packed {
      logic [1:0]     op;
      logic [15:0]    start;
      logic [16:0]    len;
      logic [15:0]    off;
      logic [7:0]     wb;
      logic           fixed;
      logic [7:0]     rd;
      fes_status_type st;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [16:0] csr_wdata;

   fes_req_if req_bus();
   fes_rsp_if rsp_bus();

   flash_eeprom_byte_store #(.MEM_BYTES(MEM_BYTES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   logic [7:0] shadow_cells [0:MEM_BYTES-1];
   logic shadow_txn_failed;
   fes_cfg_type shadow_cfg;
   byte_result_t pending_results[$];
   int mismatches = 0;
   int items_sent = 0;
   int stall_cycles = 0;
   logic calm = 1'b0;

   directed_row_t directed_rows [25] = '{
      '{OP_READ,    16'h0000, 17'd1,      16'd0,    8'h00, 1'b1, ERASED_BYTE, ST_OK},
      '{OP_READ,    16'hFFFF, 17'd1,      16'd0,    8'hFF, 1'b1, ERASED_BYTE, ST_OK},
      '{OP_READ,    16'h0000, 17'd0,      16'd0,    8'h00, 1'b1, 8'h00, ST_INVALID},
      '{OP_READ,    16'h0000, 17'h10000,  16'd0,    8'h00, 1'b1, 8'h00, ST_INVALID},
      '{OP_READ,    16'h0001, 17'h0FFFF,  16'hFFFE, 8'h00, 1'b1, ERASED_BYTE, ST_OK},
      '{OP_READ,    16'h0002, 17'h0FFFF,  16'd0,    8'h00, 1'b1, 8'h00, ST_INVALID},
      '{OP_READ,    16'h0010, 17'd4,      16'd4,    8'h00, 1'b1, 8'h00, ST_INVALID},
      '{OP_UNKNOWN, 16'h0000, 17'd1,      16'd0,    8'h5A, 1'b1, 8'h00, ST_INVALID},
      '{OP_PROGRAM, 16'h0001, 17'd1,      16'd0,    8'h00, 1'b1, 8'h00, ST_INVALID},
      '{OP_PROGRAM, 16'h0008, 17'd4,      16'd0,    8'h0F, 1'b1, 8'h00, ST_OK},
      '{OP_PROGRAM, 16'h0008, 17'd4,      16'd1,    8'hA5, 1'b1, 8'h00, ST_OK},
      '{OP_PROGRAM, 16'h0008, 17'd4,      16'd2,    8'h00, 1'b1, 8'h00, ST_OK},
      '{OP_READ,    16'h0008, 17'd3,      16'd0,    8'h00, 1'b1, 8'h0F, ST_OK},
      '{OP_READ,    16'h0008, 17'd3,      16'd1,    8'h00, 1'b1, 8'hA5, ST_OK},
      '{OP_PROGRAM, 16'h0008, 17'd4,      16'd0,    8'h0E, 1'b0, 8'h00, ST_OK},
      '{OP_PROGRAM, 16'h0008, 17'd4,      16'd1,    8'hFF, 1'b1, 8'h00, ST_BITSET},
      '{OP_PROGRAM, 16'h0008, 17'd4,      16'd2,    8'h00, 1'b1, 8'h00, ST_SKIPPED},
      '{OP_PROGRAM, 16'h0008, 17'd4,      16'd3,    8'h00, 1'b1, 8'h00, ST_SKIPPED},
      '{OP_ERASE,   16'h0000, 17'd2048,   16'd9,    8'h00, 1'b1, 8'h00, ST_OK},
      '{OP_ERASE,   16'h0400, 17'd2048,   16'd0,    8'h00, 1'b1, 8'h00, ST_INVALID},
      '{OP_ERASE,   16'h0000, 17'd1024,   16'd0,    8'h00, 1'b1, 8'h00, ST_INVALID},
      '{OP_READ,    16'h0008, 17'd4,      16'd0,    8'h00, 1'b0, 8'h00, ST_OK},
      '{OP_READ,    16'h0008, 17'd4,      16'd1,    8'h00, 1'b0, 8'h00, ST_OK},
      '{OP_PROGRAM, 16'hFFF8, 17'd8,      16'd7,    8'h3C, 1'b0, 8'h00, ST_OK},
      '{OP_PROGRAM, 16'hFFF8, 17'd9,      16'd0,    8'h00, 1'b1, 8'h00, ST_INVALID}
   };

   fes_cfg_type phase_cfgs [7] = '{
      '{1'b0, 17'd256,    4'd0,  5'd0},
      '{1'b1, 17'd1,      4'd0,  5'd0},
      '{1'b1, 17'h1FFFF,  4'd15, 5'd31},
      '{1'b1, 17'h10000,  4'd0,  5'd16},
      '{1'b1, 17'd4096,   4'd2,  5'd2},
      '{1'b0, 17'h0FFFF,  4'd4,  5'd5},
      '{1'b1, 17'd1000,   4'd1,  5'd3}
   };
   int phase_items [7] = '{110, 50, 80, 80, 160, 100, 100};

   function automatic int unsigned gap_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned usable_bytes();
      return (shadow_cfg.storage_bytes > MEM_BYTES) ? MEM_BYTES
                                                    : 32'(shadow_cfg.storage_bytes);
   endfunction

   function automatic logic unit_aligned(input logic [63:0] v, input logic [4:0] lg);
      return (v & ((64'd1 << lg) - 64'd1)) == 64'd0;
   endfunction

   // Byte-store predictor: applies one beat to the shadow array and returns its result.
   function automatic void store_byte_predict(input byte_req_t it, output byte_result_t res);
      logic [63:0] lim;
      logic [63:0] s;
      logic [63:0] l;
      logic ok;
      logic [15:0] addr;
      logic [7:0] cur;
      lim = 64'(usable_bytes());
      s = 64'(it.start);
      l = 64'(it.len);
      if (it.off == 16'd0) shadow_txn_failed = 1'b0;
      ok = (l != 64'd0) && (s + l <= lim) && (it.off < it.len);
      case (it.op)
         OP_READ:    ok = ok && (it.len <= MAX_READ_LEN);
         OP_PROGRAM: ok = ok && (!shadow_cfg.flash_mode ||
                                 unit_aligned(s, shadow_cfg.program_unit_log2));
         OP_ERASE:   ok = ok && shadow_cfg.flash_mode &&
                          unit_aligned(s, shadow_cfg.erase_unit_log2) &&
                          unit_aligned(l, shadow_cfg.erase_unit_log2);
         default:    ok = 1'b0;
      endcase
      addr = it.start + it.off;
      res.read_byte = 8'h00;
      res.status = ST_OK;
      if (!ok) begin
         res.status = ST_INVALID;
      end else if (it.op == OP_READ) begin
         res.read_byte = shadow_cells[addr];
      end else if (it.op == OP_ERASE) begin
         shadow_cells[addr] = ERASED_BYTE;
      end else if (shadow_txn_failed) begin
         res.status = ST_SKIPPED;
      end else if (shadow_cfg.flash_mode) begin
         cur = shadow_cells[addr];
         if ((cur & it.wb) != it.wb) begin
            res.status = ST_BITSET;
            shadow_txn_failed = 1'b1;
         end else begin
            shadow_cells[addr] = cur & it.wb;
         end
      end else begin
         shadow_cells[addr] = it.wb;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic put_byte(input byte_req_t it, input logic use_fixed,
                           input logic [7:0] fixed_rd, input fes_status_type fixed_st);
      int unsigned gap;
      byte_result_t res;
      gap = gap_len();
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.req_type    = it.op;
      req_bus.start_addr  = it.start;
      req_bus.txn_length  = it.len;
      req_bus.byte_offset = it.off;
      req_bus.write_byte  = it.wb;
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      store_byte_predict(it, res);
      if (use_fixed) begin
         res.read_byte = fixed_rd;
         res.status = fixed_st;
      end
      pending_results.push_back(res);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_FLASH_MODE:   shadow_cfg.flash_mode = val[0];
         CSR_STORAGE:      shadow_cfg.storage_bytes = val;
         CSR_PROGRAM_UNIT: shadow_cfg.program_unit_log2 = val[3:0];
         CSR_ERASE_UNIT:   shadow_cfg.erase_unit_log2 = val[4:0];
         default: ;
      endcase
   endtask

   // One transaction: mostly well formed with random content, some noise.
   task automatic send_txn();
      byte_req_t it;
      int unsigned lim;
      int unsigned lg;
      int unsigned unit;
      int unsigned span;
      int unsigned cnt;
      int unsigned first;
      int unsigned pick;
      int unsigned i;
      lim = usable_bytes();
      pick = $urandom_range(0, 99);
      it.op = (pick < 45) ? OP_PROGRAM : (pick < 78) ? OP_READ :
              (pick < 96) ? OP_ERASE : OP_UNKNOWN;
      lg = 0;
      if (it.op == OP_ERASE) lg = 32'(shadow_cfg.erase_unit_log2);
      else if (it.op == OP_PROGRAM && shadow_cfg.flash_mode)
         lg = 32'(shadow_cfg.program_unit_log2);
      unit = 1 << ((lg > 16) ? 16 : lg);
      if ($urandom_range(0, 9) == 0 || unit > lim) begin
         it.start = 16'($urandom);
         it.len = 17'($urandom);
      end else begin
         it.start = 16'(($urandom_range(0, lim - 1) / unit) * unit);
         span = lim - 32'(it.start);
         if (it.op == OP_ERASE) begin
            if (span < unit) it.len = 17'(unit);
            else it.len = 17'($urandom_range(1, (span / unit > 4) ? 4 : span / unit) * unit);
         end else if ($urandom_range(0, 7) == 0) begin
            it.len = 17'($urandom_range(1, span));
         end else begin
            it.len = 17'($urandom_range(1, (span < 16) ? span : 16));
         end
      end
      if (it.len == 17'd0) cnt = 1;
      else if (it.len < 12) cnt = 32'(it.len);
      else cnt = $urandom_range(1, 12);
      first = 0;
      if (it.len > cnt && $urandom_range(0, 9) == 0)
         first = $urandom_range(0, 32'(it.len) - cnt);
      for (i = 0; i < cnt; i++) begin
         it.off = 16'(first + i);
         if (it.op == OP_PROGRAM && shadow_cfg.flash_mode && $urandom_range(0, 3) != 0)
            it.wb = shadow_cells[16'(it.start + it.off)] & 8'($urandom);
         else
            it.wb = 8'($urandom);
         put_byte(it, 1'b0, 8'h00, ST_OK);
      end
      if ($urandom_range(0, 9) == 0) begin
         it.off = (it.len > MAX_READ_LEN) ? 16'($urandom) : 16'($urandom_range(it.len, 65535));
         it.wb = 8'($urandom);
         put_byte(it, 1'b0, 8'h00, ST_OK);
      end
   endtask

   task automatic random_phase(input int count);
      int target;
      int half;
      logic paused;
      target = items_sent + count;
      half = items_sent + count / 2;
      paused = 1'b0;
      while (items_sent < target) begin
         send_txn();
         if (!paused && items_sent >= half) begin
            paused = 1'b1;
            drain_results();
         end
      end
   endtask

   // result side: random back-pressure
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready = 1'b0;
            hold--;
         end else begin
            rsp_bus.ready = 1'b1;
            hold = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      byte_result_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending",
                            int'({rsp_bus.read_byte, rsp_bus.status}), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.read_byte !== want.read_byte)
               report_mismatch("read_byte", int'(rsp_bus.read_byte), int'(want.read_byte));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", int'(rsp_bus.status), int'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      byte_req_t it;
      directed_row_t r;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_FLASH_MODE;
      csr_wdata = 17'd0;
      req_bus.valid = 1'b0;
      req_bus.req_type = OP_READ;
      req_bus.start_addr = 16'd0;
      req_bus.txn_length = 17'd0;
      req_bus.byte_offset = 16'd0;
      req_bus.write_byte = 8'd0;
      for (int i = 0; i < MEM_BYTES; i++) shadow_cells[i] = ERASED_BYTE;
      shadow_txn_failed = 1'b0;
      shadow_cfg = '{1'b1, 17'h10000, 4'd3, 5'd11};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         it = '{r.op, r.start, r.len, r.off, r.wb};
         put_byte(it, r.fixed, r.rd, r.st);
      end
      random_phase(100);

      for (int p = 0; p < 7; p++) begin
         drain_results();
         repeat (4) @(posedge clock);
         write_reg(CSR_FLASH_MODE, 17'(phase_cfgs[p].flash_mode));
         write_reg(CSR_STORAGE, phase_cfgs[p].storage_bytes);
         write_reg(CSR_PROGRAM_UNIT, 17'(phase_cfgs[p].program_unit_log2));
         write_reg(CSR_ERASE_UNIT, 17'(phase_cfgs[p].erase_unit_log2));
         calm = (p == 2 || p == 5);
         random_phase(phase_items[p]);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
